### hw/rtl/vrm_pkg.sv
package vrm_pkg;

    // world geometry
    localparam int CHUNKS_X     = 4;
    localparam int CHUNKS_Z     = 4;
    localparam int CHUNK_SPAN_X = 16;
    localparam int CHUNK_SPAN_Z = 16;
    localparam int CHUNK_LAYERS = 32;
    localparam int WORLD_COLS   = CHUNKS_X * CHUNK_SPAN_X;
    localparam int WORLD_ROWS   = CHUNKS_Z * CHUNK_SPAN_Z;

    // voxel store
    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = 17;
    // wide enough for any linear index of an in-bounds cell
    localparam int IDX_W       = 33;

    // Q12.12 coordinates
    localparam int Q_W    = 24;
    localparam int FRAC_W = 12;
    localparam int CELL_W = Q_W - 1 - FRAC_W;

    // step = round(dir / 25): floor((2*|d| + 25) / 50) by reciprocal multiply
    localparam int STEP_DIVISOR = 25;
    localparam int RECIP_SHIFT  = 31;
    localparam int RECIP_W      = 26;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(42949673);
    localparam int NUM_W        = Q_W + 1;
    localparam int PROD_W       = NUM_W + RECIP_W;

    localparam int ID_W    = 8;
    localparam int STEPS_W = 16;

    // configuration register indexes
    localparam logic CFG_AIR_BLOCK_ID = 1'b0;
    localparam logic CFG_MAX_STEPS    = 1'b1;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_TEST
    } t_state;

    typedef struct packed {
        logic wr;
        logic load;
        logic div_step;
        logic probe;
        logic advance;
        logic finish_hit;
        logic finish_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic outside;
        logic solid;
        logic at_limit;
    } t_dp_status;

endpackage

### hw/rtl/vrm_ctrl.sv
module vrm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_command,
    input  vrm_pkg::t_dp_status i_sts,
    output vrm_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    vrm_pkg::t_state r_state;
    vrm_pkg::t_state n_state;
    logic            accept;

    assign accept = i_start && (r_state == vrm_pkg::ST_IDLE);
    assign o_busy = (r_state != vrm_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vrm_pkg::ST_IDLE: begin
                if (accept && i_command == vrm_pkg::CMD_CAST) begin
                    n_state = vrm_pkg::ST_DIV;
                end
            end
            vrm_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = vrm_pkg::ST_PROBE;
                end
            end
            vrm_pkg::ST_PROBE: begin
                if (i_sts.outside) begin
                    n_state = vrm_pkg::ST_IDLE;
                end else begin
                    n_state = vrm_pkg::ST_TEST;
                end
            end
            vrm_pkg::ST_TEST: begin
                if (i_sts.solid || i_sts.at_limit) begin
                    n_state = vrm_pkg::ST_IDLE;
                end else begin
                    n_state = vrm_pkg::ST_PROBE;
                end
            end
            default: n_state = vrm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            vrm_pkg::ST_IDLE: begin
                o_cmd.wr   = accept && (i_command == vrm_pkg::CMD_WRITE);
                o_cmd.load = accept && (i_command == vrm_pkg::CMD_CAST);
            end
            vrm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            vrm_pkg::ST_PROBE: begin
                o_cmd.finish_miss = i_sts.outside;
                o_cmd.probe       = !i_sts.outside;
            end
            vrm_pkg::ST_TEST: begin
                // solid wins over the step limit
                o_cmd.finish_hit  = i_sts.solid;
                o_cmd.finish_miss = !i_sts.solid && i_sts.at_limit;
                o_cmd.advance     = !i_sts.solid && !i_sts.at_limit;
            end
            default: o_cmd = '0;
        endcase
    end

    a_test_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrm_pkg::ST_TEST) |-> $past(r_state == vrm_pkg::ST_PROBE))
        else $error("test state not preceded by probe");

    a_div_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrm_pkg::ST_PROBE && $past(r_state == vrm_pkg::ST_DIV))
        |-> $past(i_sts.div_done))
        else $error("march began before step vector was ready");

    a_busy_on_cast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && i_command == vrm_pkg::CMD_CAST))
        else $error("busy rose without a cast");

endmodule

### hw/rtl/vrm_dp.sv
module vrm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vrm_pkg::t_dp_cmd                    i_cmd,
    output vrm_pkg::t_dp_status                 o_sts,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_index,
    input  logic [vrm_pkg::STEPS_W-1:0]         i_cfg_data,
    input  logic [vrm_pkg::ADDR_W-1:0]          i_voxel_address,
    input  logic [vrm_pkg::ID_W-1:0]            i_voxel_value,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_origin_x,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_origin_y,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_origin_z,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_dir_x,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_dir_y,
    input  logic signed [vrm_pkg::Q_W-1:0]      i_dir_z,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [5:0]                          o_hit_x,
    output logic [4:0]                          o_hit_y,
    output logic [5:0]                          o_hit_z,
    output logic [5:0]                          o_prev_x,
    output logic [4:0]                          o_prev_y,
    output logic [5:0]                          o_prev_z,
    output logic signed [vrm_pkg::Q_W-1:0]      o_end_x,
    output logic signed [vrm_pkg::Q_W-1:0]      o_end_y,
    output logic signed [vrm_pkg::Q_W-1:0]      o_end_z
);

    logic [vrm_pkg::ID_W-1:0] r_mem [vrm_pkg::STORE_DEPTH];

    logic [vrm_pkg::ID_W-1:0]    r_air;
    logic [vrm_pkg::STEPS_W-1:0] r_max;

    logic signed [vrm_pkg::Q_W-1:0] r_point [3];
    logic signed [vrm_pkg::Q_W-1:0] r_step  [3];
    logic signed [vrm_pkg::Q_W-1:0] r_dir   [3];
    logic [vrm_pkg::STEPS_W-1:0]    r_count;
    logic [1:0]                     r_div_cnt;
    logic [vrm_pkg::PROD_W-1:0]     r_prod;
    logic                           r_prod_neg;

    logic [5:0] r_cell_x, r_prev_x;
    logic [4:0] r_cell_y, r_prev_y;
    logic [5:0] r_cell_z, r_prev_z;
    logic [vrm_pkg::ID_W-1:0] r_rd_data;

    logic                           r_valid;
    logic                           r_hit;
    logic [5:0]                     r_out_hx, r_out_px, r_out_hz, r_out_pz;
    logic [4:0]                     r_out_hy, r_out_py;
    logic signed [vrm_pkg::Q_W-1:0] r_end [3];

    // divider operand selection
    logic signed [vrm_pkg::Q_W-1:0] div_dir;
    logic [vrm_pkg::Q_W-1:0]        div_mag;
    logic [vrm_pkg::NUM_W-1:0]      div_num;
    logic [vrm_pkg::PROD_W-vrm_pkg::RECIP_SHIFT-1:0] div_q;
    logic signed [vrm_pkg::Q_W-1:0] div_step;

    // cell of the current point
    logic [vrm_pkg::CELL_W-1:0] cx, cy, cz;
    logic                       negative;
    logic                       out_bounds;
    logic [vrm_pkg::IDX_W-1:0]  idx;

    logic signed [vrm_pkg::Q_W:0]   sum [3];
    logic signed [vrm_pkg::Q_W-1:0] sat [3];

    always_comb begin
        case (r_div_cnt)
            2'd0:    div_dir = r_dir[0];
            2'd1:    div_dir = r_dir[1];
            default: div_dir = r_dir[2];
        endcase
        div_mag  = div_dir[vrm_pkg::Q_W-1] ? vrm_pkg::Q_W'(-div_dir) : vrm_pkg::Q_W'(div_dir);
        div_num  = {div_mag, 1'b0} + vrm_pkg::NUM_W'(vrm_pkg::STEP_DIVISOR);
        div_q    = r_prod[vrm_pkg::PROD_W-1:vrm_pkg::RECIP_SHIFT];
        div_step = r_prod_neg ? -vrm_pkg::Q_W'(div_q) : vrm_pkg::Q_W'(div_q);
    end

    always_comb begin
        cx       = r_point[0][vrm_pkg::Q_W-2:vrm_pkg::FRAC_W];
        cy       = r_point[1][vrm_pkg::Q_W-2:vrm_pkg::FRAC_W];
        cz       = r_point[2][vrm_pkg::Q_W-2:vrm_pkg::FRAC_W];
        negative = r_point[0][vrm_pkg::Q_W-1] || r_point[1][vrm_pkg::Q_W-1]
                || r_point[2][vrm_pkg::Q_W-1];
        idx = (vrm_pkg::IDX_W'(cy) * vrm_pkg::IDX_W'(vrm_pkg::WORLD_ROWS) + vrm_pkg::IDX_W'(cz))
            * vrm_pkg::IDX_W'(vrm_pkg::WORLD_COLS) + vrm_pkg::IDX_W'(cx);
        out_bounds = (int'(cx) >= vrm_pkg::WORLD_COLS)
                  || (int'(cy) >= vrm_pkg::CHUNK_LAYERS)
                  || (int'(cz) >= vrm_pkg::WORLD_ROWS)
                  || (idx >= vrm_pkg::IDX_W'(vrm_pkg::STORE_DEPTH));
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = {r_point[k][vrm_pkg::Q_W-1], r_point[k]}
                   + {r_step[k][vrm_pkg::Q_W-1], r_step[k]};
            if (sum[k][vrm_pkg::Q_W] != sum[k][vrm_pkg::Q_W-1]) begin
                sat[k] = sum[k][vrm_pkg::Q_W] ? {1'b1, {(vrm_pkg::Q_W-1){1'b0}}}
                                              : {1'b0, {(vrm_pkg::Q_W-1){1'b1}}};
            end else begin
                sat[k] = sum[k][vrm_pkg::Q_W-1:0];
            end
        end
    end

    assign o_sts.div_done = (r_div_cnt == 2'd3);
    assign o_sts.outside  = negative || out_bounds;
    assign o_sts.solid    = (r_rd_data != r_air);
    assign o_sts.at_limit = (r_count >= r_max);

    // voxel store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_voxel_address] <= i_voxel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            r_rd_data <= r_mem[idx[vrm_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air <= '0;
            r_max <= vrm_pkg::STEPS_W'(4096);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vrm_pkg::CFG_AIR_BLOCK_ID: r_air <= i_cfg_data[vrm_pkg::ID_W-1:0];
                vrm_pkg::CFG_MAX_STEPS:    r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_div_cnt <= '0;
                r_count   <= '0;
            end else begin
                if (i_cmd.div_step) begin
                    r_div_cnt <= r_div_cnt + 2'd1;
                end
                if (i_cmd.advance) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_point[0] <= i_origin_x;
            r_point[1] <= i_origin_y;
            r_point[2] <= i_origin_z;
            r_dir[0]   <= i_dir_x;
            r_dir[1]   <= i_dir_y;
            r_dir[2]   <= i_dir_z;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_z   <= '0;
        end
        // two-stage reciprocal multiply, one axis per cycle
        if (i_cmd.div_step) begin
            if (r_div_cnt != 2'd3) begin
                r_prod     <= vrm_pkg::PROD_W'(div_num) * vrm_pkg::PROD_W'(vrm_pkg::RECIP);
                r_prod_neg <= div_dir[vrm_pkg::Q_W-1];
            end
            case (r_div_cnt)
                2'd1:    r_step[0] <= div_step;
                2'd2:    r_step[1] <= div_step;
                2'd3:    r_step[2] <= div_step;
                default: ;
            endcase
        end
        if (i_cmd.probe) begin
            r_cell_x <= cx[5:0];
            r_cell_y <= cy[4:0];
            r_cell_z <= cz[5:0];
        end
        if (i_cmd.advance) begin
            r_prev_x <= r_cell_x;
            r_prev_y <= r_cell_y;
            r_prev_z <= r_cell_z;
            for (int k = 0; k < 3; k++) begin
                r_point[k] <= sat[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish_hit || i_cmd.finish_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_hit) begin
            r_hit    <= 1'b1;
            r_out_hx <= r_cell_x;
            r_out_hy <= r_cell_y;
            r_out_hz <= r_cell_z;
            r_out_px <= r_prev_x;
            r_out_py <= r_prev_y;
            r_out_pz <= r_prev_z;
            for (int k = 0; k < 3; k++) begin
                r_end[k] <= r_point[k];
            end
        end else if (i_cmd.finish_miss) begin
            r_hit    <= 1'b0;
            r_out_hx <= '0;
            r_out_hy <= '0;
            r_out_hz <= '0;
            r_out_px <= '0;
            r_out_py <= '0;
            r_out_pz <= '0;
            for (int k = 0; k < 3; k++) begin
                r_end[k] <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_hit    = r_hit;
    assign o_hit_x  = r_out_hx;
    assign o_hit_y  = r_out_hy;
    assign o_hit_z  = r_out_hz;
    assign o_prev_x = r_out_px;
    assign o_prev_y = r_out_py;
    assign o_prev_z = r_out_pz;
    assign o_end_x  = r_end[0];
    assign o_end_y  = r_end[1];
    assign o_end_z  = r_end[2];

endmodule

### hw/rtl/voxel_ray_march_top.sv
// Fixed-step voxel ray marcher.
// Command channel: an item is taken on a clock edge with i_start high and
// o_busy low. i_command selects a voxel write (store i_voxel_value at
// i_voxel_address) or a ray cast (origin and direction in signed Q12.12).
// Writes leave o_busy low and give no result; load every
// voxel the rays can reach before casting.
// A cast raises o_busy and gives exactly one result: o_valid is high for one
// cycle with o_hit, the hit and previous cells and the end point. On a miss
// every field but o_valid is zero. The receiver cannot hold a result off.
// A cast first forms the step vector (one shared reciprocal multiplier, one
// axis per cycle), then tests each in-world cell (voxel read address, then
// registered read data and compare) and then shows the result strobe. A ray
// that leaves the world ends at the probe of the out-of-world point. At most
// max_steps + 1 cells are tested. o_busy drops in the cycle the result shows,
// so the next item may start then.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 air_block_id,
// 1 max_steps) and i_cfg_data; writes are taken in any cycle, only while idle
// is the effect defined.
// Reset (i_rst_n low, synchronous) returns to idle, air id 0, max_steps 4096;
// the voxel store keeps its contents and is undefined until written.
module voxel_ray_march_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_command,
    input  logic [vrm_pkg::ADDR_W-1:0]     i_voxel_address,
    input  logic [vrm_pkg::ID_W-1:0]       i_voxel_value,
    input  logic signed [vrm_pkg::Q_W-1:0] i_origin_x,
    input  logic signed [vrm_pkg::Q_W-1:0] i_origin_y,
    input  logic signed [vrm_pkg::Q_W-1:0] i_origin_z,
    input  logic signed [vrm_pkg::Q_W-1:0] i_dir_x,
    input  logic signed [vrm_pkg::Q_W-1:0] i_dir_y,
    input  logic signed [vrm_pkg::Q_W-1:0] i_dir_z,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [vrm_pkg::STEPS_W-1:0]    i_cfg_data,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic [5:0]                     o_hit_x,
    output logic [4:0]                     o_hit_y,
    output logic [5:0]                     o_hit_z,
    output logic [5:0]                     o_prev_x,
    output logic [4:0]                     o_prev_y,
    output logic [5:0]                     o_prev_z,
    output logic signed [vrm_pkg::Q_W-1:0] o_end_x,
    output logic signed [vrm_pkg::Q_W-1:0] o_end_y,
    output logic signed [vrm_pkg::Q_W-1:0] o_end_z
);

    vrm_pkg::t_dp_cmd    cmd;
    vrm_pkg::t_dp_status sts;

    assign o_cfg_ready = 1'b1;

    vrm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (o_busy)
    );

    vrm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_hit_z         (o_hit_z),
        .o_prev_x        (o_prev_x),
        .o_prev_y        (o_prev_y),
        .o_prev_z        (o_prev_z),
        .o_end_x         (o_end_x),
        .o_end_y         (o_end_y),
        .o_end_z         (o_end_z)
    );

endmodule
